// ===== hw/rtl/swm_pkg.sv =====
// Shared types and constants for the sliding window median filter.
// Holds the transfer payload structs and the control structs of the cell rows.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

	localparam int unsigned MAX_WINDOW_DEF = 64;
	localparam int unsigned SAMPLE_BITS    = 16;
	localparam int unsigned CFG_BITS       = 7;
	localparam int unsigned MEDIAN_BITS    = SAMPLE_BITS + 1;
	localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(3);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [MEDIAN_BITS-1:0] median_t;
	typedef logic [CFG_BITS-1:0]           cfg_word_t;

	typedef struct packed {
		sample_t sample;
		logic    sample_present;
	} in_item_t;

	typedef struct packed {
		median_t median_half_units;
		logic    median_valid;
	} out_item_t;

	// Control of the history row: push a new sample in, or rotate by one.
	typedef struct packed {
		logic push;
		logic rotate;
	} hist_ctl_t;

	// Control of the sorting row: empty it, insert a value, or shift to the head.
	typedef struct packed {
		logic clear;
		logic insert;
		logic shift;
	} sort_ctl_t;

endpackage : swm_pkg

`default_nettype wire

// ===== hw/rtl/sliding_window_median_top.sv =====
// Sliding window median filter, top level; uses swm_pkg, swm_hist_cell, swm_sort_cell.
// An accepted item passes through a full history rotation, a drain of the sorted row up
// to its middle (skipped when the window holds no present sample) and the result register.
// A new item is taken only after the previous one has loaded the result register, which
// waits while an earlier result has not yet been taken downstream.
// Reset (asynchronous, active low) marks all history missing and sets window_length to 3.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median_top import swm_pkg::*; #(
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item,
	input  wire logic      cfg_we,
	input  wire cfg_word_t cfg_wdata
);

	// KW indexes a history position; WCW holds a count up to MAX_WINDOW itself.
	localparam int unsigned KW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int unsigned WCW = $clog2(MAX_WINDOW + 1);

	// The sequencer walks IDLE -> ROT -> DRAIN -> FIN -> IDLE for every item.
	// DRAIN is skipped when the window holds no present sample.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ROT   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t           state_q;
	cfg_word_t        window_length_q;
	logic [31:0]      wl_wide;
	logic [WCW-1:0]   w_eff;
	logic [KW-1:0]    rot_k_q;
	logic [WCW-1:0]   cnt_q;
	logic [WCW-1:0]   cnt_after;
	logic [WCW-1:0]   drain_j_q;
	logic [WCW-1:0]   half;
	logic [WCW-1:0]   seen_q;
	logic [WCW-1:0]   seen_clamp;
	sample_t          lo_q;
	sample_t          hi_q;
	logic             out_valid_q;
	out_item_t        out_item_q;
	logic             accept;
	logic             in_win;
	logic             rot_last;
	logic             load_out;
	logic             result_ok;
	median_t          pair_sum;
	hist_ctl_t        hist_ctl;
	sort_ctl_t        sort_ctl;

	sample_t hist_v [MAX_WINDOW];
	logic    hist_p [MAX_WINDOW];
	sample_t sort_v [MAX_WINDOW];
	logic    sort_gt [MAX_WINDOW];
	logic    sort_ok [MAX_WINDOW];

	// Sole config register; users write only while the block is idle (unchecked).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			window_length_q <= cfg_wdata;
		end
	end

	// A length of zero behaves as one; anything above the row length is clamped.
	always_comb begin
		wl_wide = 32'(window_length_q);
		if (wl_wide == 32'd0) begin
			w_eff = WCW'(1);
		end else if (wl_wide > 32'(MAX_WINDOW)) begin
			w_eff = WCW'(MAX_WINDOW);
		end else begin
			w_eff = WCW'(wl_wide);
		end
	end

	// A new item is taken only between items; a result still waiting downstream holds
	// the sequencer in FIN, and so holds up the next input transfer as well.
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// The history row is a shift line ordered by age: cell 0 holds the newest sample.
	// During ROT it rotates towards cell 0, so cell 0 shows ages 0, 1, 2 and so on in
	// turn, and after a full rotation the row is back in its original order.
	assign rot_last = (rot_k_q == KW'(MAX_WINDOW - 1));
	assign in_win   = (WCW'(rot_k_q) < w_eff);

	always_comb begin
		hist_ctl.push   = accept;
		hist_ctl.rotate = (state_q == ST_ROT);
		sort_ctl.clear  = accept;
		sort_ctl.insert = (state_q == ST_ROT) && in_win && hist_p[0];
		sort_ctl.shift  = (state_q == ST_DRAIN);
	end

	generate
		for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cells
			sample_t push_v;
			logic    push_p;
			sample_t rot_v;
			logic    rot_p;
			sample_t left_v;
			logic    left_gt;
			logic    left_ok;
			sample_t right_v;

			if (i == 0) begin : g_head
				assign push_v  = in_item.sample;
				assign push_p  = in_item.sample_present;
				assign left_v  = '0;
				assign left_gt = 1'b0;
				assign left_ok = 1'b1;
			end else begin : g_body
				assign push_v  = hist_v[i-1];
				assign push_p  = hist_p[i-1];
				assign left_v  = sort_v[i-1];
				assign left_gt = sort_gt[i-1];
				assign left_ok = sort_ok[i-1];
			end

			if (i == MAX_WINDOW - 1) begin : g_tail
				assign rot_v   = hist_v[0];
				assign rot_p   = hist_p[0];
				assign right_v = '0;
			end else begin : g_inner
				assign rot_v   = hist_v[i+1];
				assign rot_p   = hist_p[i+1];
				assign right_v = sort_v[i+1];
			end

			swm_hist_cell u_hist (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (hist_ctl),
				.push_v (push_v),
				.push_p (push_p),
				.rot_v  (rot_v),
				.rot_p  (rot_p),
				.p      (hist_p[i]),
				.v      (hist_v[i])
			);

			// Every sorting cell sees the value at the head of the history row.
			swm_sort_cell u_sort (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (sort_ctl),
				.x       (hist_v[0]),
				.left_v  (left_v),
				.left_gt (left_gt),
				.left_ok (left_ok),
				.right_v (right_v),
				.v       (sort_v[i]),
				.gt      (sort_gt[i]),
				.ok      (sort_ok[i])
			);
		end
	endgenerate

	assign cnt_after = cnt_q + (sort_ctl.insert ? WCW'(1) : WCW'(0));
	assign half      = cnt_q >> 1;

	// The count of items seen is clamped to the current window before it advances,
	// so a window that has just been lengthened stays invalid until it fills again.
	assign seen_clamp = (seen_q > w_eff) ? w_eff : seen_q;

	assign load_out = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rot_k_q   <= '0;
			cnt_q     <= '0;
			drain_j_q <= '0;
			seen_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ROT;
						rot_k_q <= '0;
						cnt_q   <= '0;
						seen_q  <= (seen_clamp < w_eff) ? seen_clamp + WCW'(1) : seen_clamp;
					end
				end
				ST_ROT: begin
					cnt_q <= cnt_after;
					if (rot_last) begin
						rot_k_q   <= '0;
						drain_j_q <= '0;
						state_q   <= (cnt_after != '0) ? ST_DRAIN : ST_FIN;
					end else begin
						rot_k_q <= rot_k_q + KW'(1);
					end
				end
				ST_DRAIN: begin
					drain_j_q <= drain_j_q + WCW'(1);
					if (drain_j_q == half) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The sorted row drains towards cell 0 one place a cycle, so after j shifts cell 0
	// holds the j-th smallest value. The two middle values are caught on the way past;
	// for an odd count both registers take the single middle value.
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			if (drain_j_q == half) begin
				hi_q <= sort_v[0];
				if (cnt_q[0]) begin
					lo_q <= sort_v[0];
				end
			end else if (drain_j_q == half - WCW'(1)) begin
				lo_q <= sort_v[0];
			end
		end
	end

	// The sum of the two middle values is exact in one extra bit: twice the median.
	assign result_ok = (seen_q >= w_eff) && (cnt_q != '0);
	assign pair_sum  = median_t'(lo_q) + median_t'(hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && load_out) begin
			out_item_q.median_valid      <= result_ok;
			out_item_q.median_half_units <= result_ok ? pair_sum : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// An invalid result always carries a zero median.
	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.median_valid || (out_item.median_half_units == '0)))
		else $error("invalid result with a non-zero median");

	// An input transfer always starts a fresh rotation with an empty sorting row.
	a_accept_starts_rot: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ((state_q == ST_ROT) && (rot_k_q == '0) && (cnt_q == '0)))
		else $error("input transfer did not start a fresh rotation");

	// While an item is under way the sorting row never holds more values than the
	// window has positions.
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (cnt_q <= w_eff))
		else $error("sorted count exceeds window length");

	// Draining only happens with at least one present sample, and stops by the middle.
	a_drain_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> ((cnt_q != '0) && (drain_j_q <= half)))
		else $error("drain ran on an empty row or past the middle");

endmodule : sliding_window_median_top

`default_nettype wire

// ===== hw/rtl/swm_hist_cell.sv =====
// One position of the sample history row of the median filter.
// Depends on swm_pkg for the sample type and the row control struct.
`timescale 1ns / 1ps
`default_nettype none

module swm_hist_cell import swm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire hist_ctl_t ctl,
	input  wire sample_t   push_v,
	input  wire logic      push_p,
	input  wire sample_t   rot_v,
	input  wire logic      rot_p,
	output logic           p,
	output sample_t        v
);

	sample_t v_q;
	logic    p_q;

	// Presence is control state and clears on reset; the value is payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= 1'b0;
		end else if (ctl.push) begin
			p_q <= push_p;
		end else if (ctl.rotate) begin
			p_q <= rot_p;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			v_q <= push_v;
		end else if (ctl.rotate) begin
			v_q <= rot_v;
		end
	end

	assign v = v_q;
	assign p = p_q;

endmodule : swm_hist_cell

`default_nettype wire

// ===== hw/rtl/swm_sort_cell.sv =====
// One slot of the insertion sorting row of the median filter.
// Depends on swm_pkg for the sample type and the row control struct.
`timescale 1ns / 1ps
`default_nettype none

module swm_sort_cell import swm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire sort_ctl_t ctl,
	input  wire sample_t   x,
	input  wire sample_t   left_v,
	input  wire logic      left_gt,
	input  wire logic      left_ok,
	input  wire sample_t   right_v,
	output sample_t        v,
	output logic           gt,
	output logic           ok
);

	sample_t v_q;
	logic    ok_q;
	logic    take;

	// The occupied slots form a sorted prefix, so the slots holding values
	// above x form a suffix of it. Each of those moves one place up, and the
	// slot just above the last value not above x receives x.
	assign gt   = ok_q && (v_q > x);
	assign take = gt || (!ok_q && left_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else if (ctl.clear) begin
			ok_q <= 1'b0;
		end else if (ctl.insert && take) begin
			ok_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert && take) begin
			v_q <= left_gt ? left_v : x;
		end else if (ctl.shift) begin
			v_q <= right_v;
		end
	end

	assign v  = v_q;
	assign ok = ok_q;

endmodule : swm_sort_cell

`default_nettype wire

// ===== sim/tb_sliding_window_median_top.sv =====
// Self-checking testbench for the sliding window median filter top level.
// Depends on swm_pkg and sliding_window_median_top; a behavioural model inside predicts
// every result, and random idling on both channels stresses the valid/ready handshakes.
`timescale 1ns / 1ps

module tb_sliding_window_median_top;
	import swm_pkg::*;

	localparam int unsigned RING_DEPTH = MAX_WINDOW_DEF;
	// Settling wait for the slowest sample, which rotates the history and drains the sorted row.
	localparam int unsigned BLOCK_LATENCY = RING_DEPTH + RING_DEPTH / 2 + 8;
	localparam int unsigned RANDOM_ITEMS = 1850;
	localparam int unsigned REPORT_LIMIT = 10;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_item   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;
	logic      cfg_we    = 1'b0;
	cfg_word_t cfg_wdata = '0;

	sliding_window_median_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// A 2 ns clock: one nanosecond low, one nanosecond high.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Idling percentages for the two channels; the random window test changes them between phases.
	int unsigned send_idle_pct = 33;
	int unsigned recv_idle_pct = 81;

	// Model of the filter state: the history ring with its present flags, the next slot to
	// write, the number of samples seen (saturating at the window) and the window register.
	sample_t     ring_value   [RING_DEPTH];
	bit          ring_present [RING_DEPTH];
	int unsigned ring_wr_pos  = 0;
	int unsigned seen_samples = 0;
	cfg_word_t   window_reg   = WINDOW_RESET;

	// Medians predicted for accepted samples, oldest first.
	out_item_t expected_medians [$];
	out_item_t oldest_median;

	int unsigned samples_sent    = 0;
	int unsigned medians_checked = 0;
	int unsigned window_writes   = 0;
	int unsigned mismatch_count  = 0;

	// Pushes one sample into the model and returns the median that the block must produce.
	// The window covers the most recent ring slots; a register value of zero acts as one
	// and anything above the ring depth acts as the full ring.
	function automatic out_item_t median_of_window(input sample_t value, input logic present);
		int unsigned eff_window;
		int unsigned n_present;
		int unsigned slot;
		int unsigned j;
		int unsigned k;
		sample_t     sorted_present [RING_DEPTH];
		sample_t     v;
		median_t     twice;
		out_item_t   result;
		eff_window = (window_reg == 0) ? 1 :
			(window_reg > RING_DEPTH) ? RING_DEPTH : int'(window_reg);
		ring_value[ring_wr_pos]   = value;
		ring_present[ring_wr_pos] = present;
		if (seen_samples > eff_window)
			seen_samples = eff_window;
		if (seen_samples < eff_window)
			seen_samples++;
		n_present = 0;
		for (k = 0; k < eff_window; k++) begin
			slot = (ring_wr_pos + RING_DEPTH - k) % RING_DEPTH;
			if (ring_present[slot]) begin
				v = ring_value[slot];
				j = n_present;
				while (j > 0 && sorted_present[j-1] > v) begin
					sorted_present[j] = sorted_present[j-1];
					j--;
				end
				sorted_present[j] = v;
				n_present++;
			end
		end
		ring_wr_pos = (ring_wr_pos + 1) % RING_DEPTH;
		result = '0;
		if (seen_samples >= eff_window && n_present > 0) begin
			// Twice the middle value for an odd count, the two middle values summed otherwise.
			if (n_present % 2)
				twice = median_t'(sorted_present[n_present/2]) +
					median_t'(sorted_present[n_present/2]);
			else
				twice = median_t'(sorted_present[n_present/2 - 1]) +
					median_t'(sorted_present[n_present/2]);
			result.median_half_units = twice;
			result.median_valid      = 1'b1;
		end
		return result;
	endfunction

	// The receiver stalls at random with the current percentage.
	always @(posedge clk)
		out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

	// Every result transfer is compared with the oldest prediction, field by field.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			medians_checked++;
			if (expected_medians.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("tb: unexpected median %0d valid %0b at %0t",
						out_item.median_half_units, out_item.median_valid, $realtime);
			end else begin
				oldest_median = expected_medians[0];
				expected_medians.delete(0);
				if (out_item.median_half_units !== oldest_median.median_half_units ||
						out_item.median_valid !== oldest_median.median_valid) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("tb: median %0d valid %0b, expected %0d valid %0b at %0t",
							out_item.median_half_units, out_item.median_valid,
							oldest_median.median_half_units, oldest_median.median_valid,
							$realtime);
				end
			end
		end
	end

	// Offers one sample and waits for its transfer. Valid is only lowered when an idle gap
	// is taken; otherwise the new payload replaces the previous one in the same step.
	task automatic send_sample(input sample_t value, input logic present);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_item  <= '{sample: value, sample_present: present};
		do
			@(posedge clk);
		while (!in_ready);
		expected_medians.insert(expected_medians.size(), median_of_window(value, present));
		samples_sent++;
	endtask

	// Stops offering samples, waits until every predicted median has arrived, then lets the
	// block settle for the requested tail.
	task automatic drain_medians(input int unsigned tail_cycles);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_medians.size() != 0)
			@(posedge clk);
		repeat (tail_cycles) @(posedge clk);
	endtask

	// Writes the window length once the block has gone quiet.
	task automatic write_window(input cfg_word_t length);
		drain_medians(8);
		cfg_wdata <= length;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we     <= 1'b0;
		window_reg  = length;
		window_writes++;
	endtask

	// The reset window of three: the first two results are invalid, then the extremes
	// meet, the window empties of present samples, and a present sample refills it.
	task automatic test_reset_window;
		send_sample(16'sh7FFF, 1'b1);
		send_sample(-16'sh8000, 1'b1);
		send_sample(16'sh0000, 1'b0);
		send_sample(-16'sh0001, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh0001, 1'b1);
	endtask

	// A window of two gives an even count, so the two extremes summed reach both ends
	// of the median range.
	task automatic test_even_extremes;
		write_window(cfg_word_t'(2));
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(-16'sh8000, 1'b1);
		send_sample(-16'sh8000, 1'b1);
		send_sample(16'sh7FFF, 1'b1);
	endtask

	// A zero length behaves as a window of one; a missing sample there leaves nothing
	// to take the median of, whatever bits the missing sample carries.
	task automatic test_zero_window;
		write_window(cfg_word_t'(0));
		send_sample(16'sh3039, 1'b1);
		send_sample(16'shFFFF, 1'b0);
		send_sample(-16'sh0005, 1'b1);
		write_window(cfg_word_t'(1));
		send_sample(16'sh5555, 1'b0);
		send_sample(16'shAAAA, 1'b1);
	endtask

	// Random phases, each with its own window length, share of present samples and value
	// pattern. The stream carries on across length changes, so longer windows pick up
	// older history and shorter ones drop it. Fixed lengths at and around the limits come first,
	// followed by mostly short windows.
	task automatic test_random_windows;
		int unsigned random_sent;
		int unsigned phase;
		int unsigned eff_window;
		int unsigned phase_len;
		int unsigned present_pct;
		int unsigned value_mode;
		int unsigned i;
		cfg_word_t   length;
		sample_t     value;
		random_sent = 0;
		phase       = 0;
		while (random_sent < RANDOM_ITEMS) begin
			// Idling profile by thirds of the random part.
			if (random_sent < RANDOM_ITEMS / 3) begin
				send_idle_pct = 33;
				recv_idle_pct = 81;
			end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 81;
				recv_idle_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (phase)
				0: length = cfg_word_t'(64);
				1: length = cfg_word_t'(1);
				2: length = cfg_word_t'(127);
				3: length = cfg_word_t'(65);
				4: length = cfg_word_t'(63);
				default: begin
					case ($urandom_range(15))
						0:       length = cfg_word_t'(0);
						1:       length = cfg_word_t'(1);
						2:       length = cfg_word_t'(64);
						3:       length = cfg_word_t'($urandom_range(127, 65));
						4, 5:    length = cfg_word_t'($urandom_range(63, 17));
						default: length = cfg_word_t'($urandom_range(16, 2));
					endcase
				end
			endcase
			write_window(length);
			eff_window = (length == 0) ? 1 : (length > RING_DEPTH) ? RING_DEPTH : int'(length);
			phase_len  = $urandom_range(40, 8) + ((eff_window > 16) ? eff_window : 0);
			case ($urandom_range(7))
				0:       present_pct = 0;
				1:       present_pct = 15;
				2:       present_pct = 50;
				3, 4:    present_pct = 90;
				default: present_pct = 100;
			endcase
			value_mode = $urandom_range(3);
			for (i = 0; i < phase_len; i++) begin
				case (value_mode)
					// Narrow spread, so ties and small even sums are frequent.
					1: value = sample_t'(int'($urandom_range(8)) - 4);
					// Close to either end of the range.
					2: value = $urandom_range(1) ? sample_t'(16'h7FFF - $urandom_range(3)) :
						sample_t'(16'h8000 + $urandom_range(3));
					default: value = sample_t'($urandom);
				endcase
				send_sample(value, $urandom_range(99) < present_pct);
			end
			random_sent += phase_len;
			phase++;
		end
	endtask

	initial begin
		foreach (ring_value[n]) begin
			ring_value[n]   = '0;
			ring_present[n] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_even_extremes();
		test_zero_window();
		test_random_windows();

		drain_medians(BLOCK_LATENCY);
		$display("tb: %0d samples sent over %0d window settings, %0d medians compared",
			samples_sent, window_writes, medians_checked);
		$display("tb: %0d mismatches", mismatch_count);
		if (mismatch_count == 0 && expected_medians.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Guard against a hung handshake: several times the slowest correct run.
	initial begin
		#4000000;
		$display("tb: timed out with %0d medians outstanding", expected_medians.size());
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== sliding_window_median_top.f =====
hw/rtl/swm_pkg.sv
hw/rtl/swm_hist_cell.sv
hw/rtl/swm_sort_cell.sv
hw/rtl/sliding_window_median_top.sv
sim/tb_sliding_window_median_top.sv
